// ===== rtl/insulation_resistance_classifier_core_defines.svh =====
// ----------------------------------------------------------------------------
// Insulation resistance classifier assertion macros
// Concurrent check helpers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef INSULATION_RESISTANCE_CLASSIFIER_CORE_DEFINES_SVH
`define INSULATION_RESISTANCE_CLASSIFIER_CORE_DEFINES_SVH

`ifndef SYNTH
`define IRC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define IRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define IRC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define IRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/irc_pkg.sv =====
// ----------------------------------------------------------------------------
// Insulation resistance classifier package
// Shared types, codes, reset values and the sequencer control store.
// ----------------------------------------------------------------------------
`default_nettype none

package irc_pkg;

  localparam int unsigned RawW     = 16;
  localparam int unsigned ThrW     = 20;
  localparam int unsigned QuotW    = 26;
  localparam int unsigned DivisorW = 13;
  localparam int unsigned StepW    = 4;
  localparam int unsigned RegIdxW  = 3;

  localparam logic [9:0]  KohmToOhm = 10'd1000;
  // floor(v / 10) == (v * 52429) >> 19 for every 16-bit v
  localparam logic [15:0] Div10Mul   = 16'd52429;
  localparam int unsigned Div10Shift = 19;

  localparam logic [ThrW-1:0]  FaultThrReset = 20'd100;
  localparam logic [ThrW-1:0]  WarnThrReset  = 20'd500;
  localparam logic [RawW-1:0]  InvCodeReset  = 16'hFFFF;
  localparam logic [RawW-1:0]  MaxCodeReset  = 16'hFFFE;
  localparam logic [QuotW-1:0] MaxSubReset   = 26'(600 * 1000);

  localparam logic [2:0] MON_INVALID   = 3'd0;
  localparam logic [2:0] MON_CHECKING  = 3'd1;
  localparam logic [2:0] MON_VALID     = 3'd2;
  localparam logic [2:0] MON_SELF_TEST = 3'd3;

  localparam logic [RegIdxW-1:0] REG_FAULT_THR = 3'd0;
  localparam logic [RegIdxW-1:0] REG_WARN_THR  = 3'd1;
  localparam logic [RegIdxW-1:0] REG_INV_CODE  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_MAX_CODE  = 3'd3;
  localparam logic [RegIdxW-1:0] REG_MAX_SUB   = 3'd4;

  typedef enum logic [2:0] {
    ST_INVALID  = 3'd0,
    ST_CHECKING = 3'd1,
    ST_VALID    = 3'd2,
    ST_WARNING  = 3'd3,
    ST_FAULT    = 3'd4
  } irc_status_e;

  typedef struct packed {
    logic self_test;
    logic neg_warn;
    logic pos_warn;
    logic neg_fault;
    logic pos_fault;
  } irc_alarm_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_PREP,
    OP_DIV_START,
    OP_DIV_WAIT,
    OP_POS_STORE,
    OP_NEG_STORE,
    OP_FINISH
  } irc_op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_SKIP_DIV,
    C_DIV_BUSY,
    C_OUT_FULL
  } irc_cond_e;

  typedef struct packed {
    irc_op_e          op;
    irc_cond_e        cond;
    logic [StepW-1:0] target;
    logic             last;
  } irc_ctrl_t;

  typedef struct packed {
    logic                start;
    logic [QuotW-1:0]    dividend;
    logic [DivisorW-1:0] divisor;
  } irc_div_req_t;

  typedef struct packed {
    logic             busy;
    logic [QuotW-1:0] quotient;
  } irc_div_rsp_t;

  localparam logic [StepW-1:0] STEP_ACCEPT    = 4'd0;
  localparam logic [StepW-1:0] STEP_PREP      = 4'd1;
  localparam logic [StepW-1:0] STEP_POS_START = 4'd2;
  localparam logic [StepW-1:0] STEP_POS_WAIT  = 4'd3;
  localparam logic [StepW-1:0] STEP_POS_STORE = 4'd4;
  localparam logic [StepW-1:0] STEP_NEG_START = 4'd5;
  localparam logic [StepW-1:0] STEP_NEG_WAIT  = 4'd6;
  localparam logic [StepW-1:0] STEP_NEG_STORE = 4'd7;
  localparam logic [StepW-1:0] STEP_FINISH    = 4'd8;

  function automatic irc_ctrl_t irc_ucode(input logic [StepW-1:0] step);
    irc_ctrl_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: STEP_ACCEPT, last: 1'b1};
    case (step)
      STEP_ACCEPT:    w = '{op: OP_ACCEPT, cond: C_NO_INPUT, target: STEP_ACCEPT, last: 1'b0};
      STEP_PREP:      w = '{op: OP_PREP, cond: C_SKIP_DIV, target: STEP_FINISH, last: 1'b0};
      STEP_POS_START: w = '{op: OP_DIV_START, cond: C_NEVER, target: STEP_ACCEPT, last: 1'b0};
      STEP_POS_WAIT:  w = '{op: OP_DIV_WAIT, cond: C_DIV_BUSY, target: STEP_POS_WAIT,
                            last: 1'b0};
      STEP_POS_STORE: w = '{op: OP_POS_STORE, cond: C_NEVER, target: STEP_ACCEPT, last: 1'b0};
      STEP_NEG_START: w = '{op: OP_DIV_START, cond: C_NEVER, target: STEP_ACCEPT, last: 1'b0};
      STEP_NEG_WAIT:  w = '{op: OP_DIV_WAIT, cond: C_DIV_BUSY, target: STEP_NEG_WAIT,
                            last: 1'b0};
      STEP_NEG_STORE: w = '{op: OP_NEG_STORE, cond: C_NEVER, target: STEP_ACCEPT, last: 1'b0};
      STEP_FINISH:    w = '{op: OP_FINISH, cond: C_OUT_FULL, target: STEP_FINISH, last: 1'b1};
      default:        w = '{op: OP_NOP, cond: C_ALWAYS, target: STEP_ACCEPT, last: 1'b1};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/irc_div.sv =====
// ----------------------------------------------------------------------------
// Insulation resistance classifier divider
// Restoring unsigned divider, one quotient bit per clock.
// ----------------------------------------------------------------------------
`default_nettype none

module irc_div (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire irc_pkg::irc_div_req_t req_i,
  output irc_pkg::irc_div_rsp_t      rsp_o
);

  localparam int unsigned CntW = $clog2(irc_pkg::QuotW + 1);

  logic                         busy_q, busy_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [irc_pkg::DivisorW-1:0] rem_q, rem_d;
  logic [irc_pkg::QuotW-1:0]    quot_q, quot_d;
  logic [irc_pkg::DivisorW:0]   trial;
  logic [irc_pkg::DivisorW:0]   diff;
  logic                         ge;

  always_comb begin
    trial = {rem_q, quot_q[irc_pkg::QuotW-1]};
    ge    = trial >= {1'b0, req_i.divisor};
    diff  = trial - {1'b0, req_i.divisor};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(irc_pkg::QuotW);
      rem_d  = '0;
      quot_d = req_i.dividend;
    end else if (busy_q) begin
      rem_d  = ge ? diff[irc_pkg::DivisorW-1:0] : trial[irc_pkg::DivisorW-1:0];
      quot_d = {quot_q[irc_pkg::QuotW-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign rsp_o = '{busy: busy_q, quotient: quot_q};

endmodule

`default_nettype wire

// ===== rtl/insulation_resistance_classifier_core.sv =====
// ----------------------------------------------------------------------------
// Insulation resistance classifier core
// Converts insulation-monitor reports to ohms per volt and tracks outlet state.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out. A report with monitor status valid
// and an outlet in range sends both poles through one shared restoring divider
// at one quotient bit per clock, driven by a microcoded step sequencer; any
// other status, or an outlet out of range, skips the divider. The result sits
// in an output register, so a new report is taken while the previous result
// waits; the sequencer waits in its last step only when that register is still
// full and stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "insulation_resistance_classifier_core_defines.svh"

module insulation_resistance_classifier_core #(
  parameter int unsigned OUTLETS = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // report channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        outlet_i,
  input  wire logic [2:0]  monitor_status_i,
  input  wire logic [15:0] positive_kohm_i,
  input  wire logic [15:0] negative_kohm_i,
  input  wire logic [15:0] bus_decivolts_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             result_outlet_o,
  output logic [2:0]       outlet_status_o,
  output logic [25:0]      positive_ohm_per_volt_o,
  output logic [25:0]      negative_ohm_per_volt_o,
  output logic             positive_fault_o,
  output logic             negative_fault_o,
  output logic             positive_warning_o,
  output logic             negative_warning_o,
  output logic             self_test_fault_o,
  output logic             unknown_status_o
);

  localparam int unsigned IdxW = (OUTLETS > 1) ? $clog2(OUTLETS) : 1;

  localparam int unsigned RawW  = irc_pkg::RawW;
  localparam int unsigned ThrW  = irc_pkg::ThrW;
  localparam int unsigned QuotW = irc_pkg::QuotW;
  localparam int unsigned DvW   = irc_pkg::DivisorW;
  localparam int unsigned StepW = irc_pkg::StepW;

  // configuration registers
  logic [ThrW-1:0]  fault_thr_q;
  logic [ThrW-1:0]  warn_thr_q;
  logic [RawW-1:0]  inv_code_q;
  logic [RawW-1:0]  max_code_q;
  logic [QuotW-1:0] max_sub_q;
  logic             cfg_wr;
  logic [irc_pkg::RegIdxW-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_thr_q <= irc_pkg::FaultThrReset;
      warn_thr_q  <= irc_pkg::WarnThrReset;
      inv_code_q  <= irc_pkg::InvCodeReset;
      max_code_q  <= irc_pkg::MaxCodeReset;
      max_sub_q   <= irc_pkg::MaxSubReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        irc_pkg::REG_FAULT_THR: fault_thr_q <= pwdata[ThrW-1:0];
        irc_pkg::REG_WARN_THR:  warn_thr_q  <= pwdata[ThrW-1:0];
        irc_pkg::REG_INV_CODE:  inv_code_q  <= pwdata[RawW-1:0];
        irc_pkg::REG_MAX_CODE:  max_code_q  <= pwdata[RawW-1:0];
        irc_pkg::REG_MAX_SUB:   max_sub_q   <= pwdata[QuotW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      irc_pkg::REG_FAULT_THR: prdata = 32'(fault_thr_q);
      irc_pkg::REG_WARN_THR:  prdata = 32'(warn_thr_q);
      irc_pkg::REG_INV_CODE:  prdata = 32'(inv_code_q);
      irc_pkg::REG_MAX_CODE:  prdata = 32'(max_code_q);
      irc_pkg::REG_MAX_SUB:   prdata = 32'(max_sub_q);
      default:                prdata = '0;
    endcase
  end

  // sequencer
  logic [StepW-1:0]   step_q, step_d;
  irc_pkg::irc_ctrl_t ctrl;
  logic               jump;
  logic               accept;
  logic               out_full;
  logic               finish_load;

  // transaction registers
  logic             outlet_q;
  logic [2:0]       monitor_q;
  logic [RawW-1:0]  praw_q, nraw_q, volts_q;
  logic [DvW-1:0]   div10_q;
  logic [QuotW-1:0] prod_q;
  logic [QuotW-1:0] pos_q, neg_q;
  logic [31:0]      volts_scaled;
  logic             in_range;

  irc_pkg::irc_div_req_t div_req;
  irc_pkg::irc_div_rsp_t div_rsp;

  logic out_valid_q;

  assign ctrl     = irc_pkg::irc_ucode(step_q);
  assign out_full = out_valid_q && out_stall_i;
  assign in_range = 32'(outlet_q) < OUTLETS;

  always_comb begin
    case (ctrl.cond)
      irc_pkg::C_NEVER:    jump = 1'b0;
      irc_pkg::C_ALWAYS:   jump = 1'b1;
      irc_pkg::C_NO_INPUT: jump = !in_valid_i;
      irc_pkg::C_SKIP_DIV: jump = (monitor_q != irc_pkg::MON_VALID) || !in_range;
      irc_pkg::C_DIV_BUSY: jump = div_rsp.busy;
      irc_pkg::C_OUT_FULL: jump = out_full;
      default:             jump = 1'b1;
    endcase
  end

  always_comb begin
    if (jump) begin
      step_d = ctrl.target;
    end else if (ctrl.last) begin
      step_d = irc_pkg::STEP_ACCEPT;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_comb begin
    in_stall_o  = ctrl.op != irc_pkg::OP_ACCEPT;
    accept      = (ctrl.op == irc_pkg::OP_ACCEPT) && in_valid_i;
    finish_load = (ctrl.op == irc_pkg::OP_FINISH) && !out_full;
    div_req     = '{start: ctrl.op == irc_pkg::OP_DIV_START, dividend: prod_q,
                    divisor: div10_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= irc_pkg::STEP_ACCEPT;
    end else begin
      step_q <= step_d;
    end
  end

  irc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // pole conversion from the divider result
  logic [RawW-1:0]  pole_raw;
  logic [QuotW-1:0] pole_val;

  always_comb begin
    pole_raw = (ctrl.op == irc_pkg::OP_NEG_STORE) ? nraw_q : praw_q;
    if (pole_raw == inv_code_q) begin
      pole_val = '0;
    end else if (pole_raw == max_code_q) begin
      pole_val = max_sub_q;
    end else if (pole_raw == '0 || div10_q == '0) begin
      pole_val = '0;
    end else begin
      pole_val = div_rsp.quotient;
    end
  end

  assign volts_scaled = 32'(volts_q) * 32'(irc_pkg::Div10Mul);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      outlet_q  <= outlet_i;
      monitor_q <= monitor_status_i;
      praw_q    <= positive_kohm_i;
      nraw_q    <= negative_kohm_i;
      volts_q   <= bus_decivolts_i;
      pos_q     <= '0;
      neg_q     <= '0;
    end
    if (ctrl.op == irc_pkg::OP_PREP) begin
      div10_q <= volts_scaled[irc_pkg::Div10Shift +: DvW];
      prod_q  <= QuotW'(praw_q) * QuotW'(irc_pkg::KohmToOhm);
    end
    if (ctrl.op == irc_pkg::OP_POS_STORE) begin
      pos_q  <= pole_val;
      prod_q <= QuotW'(nraw_q) * QuotW'(irc_pkg::KohmToOhm);
    end
    if (ctrl.op == irc_pkg::OP_NEG_STORE) begin
      neg_q <= pole_val;
    end
  end

  // per-outlet state
  irc_pkg::irc_status_e status_q [OUTLETS];
  irc_pkg::irc_alarm_t  alarm_q  [OUTLETS];
  logic [IdxW-1:0]      idx;
  irc_pkg::irc_status_e st_cur, st_new;
  irc_pkg::irc_alarm_t  fl_cur, fl_new;
  logic                 unknown;
  logic [QuotW-1:0]     fault_thr;
  logic [QuotW-1:0]     warn_thr;

  assign idx       = IdxW'(outlet_q);
  assign fault_thr = QuotW'(fault_thr_q);
  assign warn_thr  = QuotW'(warn_thr_q);

  always_comb begin
    st_cur  = status_q[idx];
    fl_cur  = alarm_q[idx];
    st_new  = st_cur;
    fl_new  = fl_cur;
    unknown = 1'b0;
    case (monitor_q)
      irc_pkg::MON_INVALID:  st_new = irc_pkg::ST_INVALID;
      irc_pkg::MON_CHECKING: st_new = irc_pkg::ST_CHECKING;
      irc_pkg::MON_VALID: begin
        if (praw_q == inv_code_q) begin
          st_new           = irc_pkg::ST_FAULT;
          fl_new.pos_fault = 1'b1;
        end
        if (nraw_q == inv_code_q) begin
          st_new           = irc_pkg::ST_FAULT;
          fl_new.neg_fault = 1'b1;
        end
        if (pos_q < fault_thr) begin
          st_new = irc_pkg::ST_FAULT;
          if (!fl_new.pos_fault) begin
            fl_new.pos_fault = 1'b1;
            fl_new.pos_warn  = 1'b0;
          end
        end else if (pos_q < warn_thr) begin
          st_new          = irc_pkg::ST_WARNING;
          fl_new.pos_warn = 1'b1;
        end
        if (neg_q < fault_thr) begin
          st_new = irc_pkg::ST_FAULT;
          if (!fl_new.neg_fault) begin
            fl_new.neg_fault = 1'b1;
            fl_new.neg_warn  = 1'b0;
          end
        end else if (neg_q < warn_thr) begin
          st_new          = irc_pkg::ST_WARNING;
          fl_new.neg_warn = 1'b1;
        end
        if (pos_q >= warn_thr && neg_q >= warn_thr) begin
          st_new          = irc_pkg::ST_VALID;
          fl_new.pos_warn = 1'b0;
          fl_new.neg_warn = 1'b0;
        end
      end
      irc_pkg::MON_SELF_TEST: begin
        st_new           = irc_pkg::ST_FAULT;
        fl_new.self_test = 1'b1;
      end
      default: unknown = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < OUTLETS; i++) begin
        status_q[i] <= irc_pkg::ST_INVALID;
        alarm_q[i]  <= '0;
      end
    end else if (finish_load && in_range) begin
      status_q[idx] <= st_new;
      alarm_q[idx]  <= fl_new;
    end
  end

  // output register
  logic                out_valid_d;
  logic                out_outlet_q;
  logic [2:0]          out_status_q;
  logic [QuotW-1:0]    out_pos_q, out_neg_q;
  irc_pkg::irc_alarm_t out_alarm_q;
  logic                out_unknown_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish_load) begin
      out_outlet_q <= outlet_q;
      if (in_range) begin
        out_status_q  <= st_new;
        out_pos_q     <= pos_q;
        out_neg_q     <= neg_q;
        out_alarm_q   <= fl_new;
        out_unknown_q <= unknown;
      end else begin
        out_status_q  <= '0;
        out_pos_q     <= '0;
        out_neg_q     <= '0;
        out_alarm_q   <= '0;
        out_unknown_q <= 1'b0;
      end
    end
  end

  assign out_valid_o             = out_valid_q;
  assign result_outlet_o         = out_outlet_q;
  assign outlet_status_o         = out_status_q;
  assign positive_ohm_per_volt_o = out_pos_q;
  assign negative_ohm_per_volt_o = out_neg_q;
  assign positive_fault_o        = out_alarm_q.pos_fault;
  assign negative_fault_o        = out_alarm_q.neg_fault;
  assign positive_warning_o      = out_alarm_q.pos_warn;
  assign negative_warning_o      = out_alarm_q.neg_warn;
  assign self_test_fault_o       = out_alarm_q.self_test;
  assign unknown_status_o        = out_unknown_q;

  `IRC_ASSERT_IMPLY(a_div_start_idle, clk_i, rst_ni, div_req.start, !div_rsp.busy)
  `IRC_ASSERT_IMPLY(a_div_busy_in_wait, clk_i, rst_ni, div_rsp.busy,
                    ctrl.op == irc_pkg::OP_DIV_WAIT)
  `IRC_ASSERT_IMPLY(a_unknown_no_value, clk_i, rst_ni, out_valid_o && unknown_status_o,
                    positive_ohm_per_volt_o == '0 && negative_ohm_per_volt_o == '0)
  `IRC_ASSERT_NEXT(a_valid_no_warn, clk_i, rst_ni,
                   finish_load && in_range && st_new == irc_pkg::ST_VALID,
                   !positive_warning_o && !negative_warning_o)

endmodule

`default_nettype wire
